/* hdl/hsirgb_pkg.sv */
// Shared constants and types for the HSI to RGB converter.
package hsirgb_pkg;

    // Default fraction bits of the sector ratio
    localparam int RATIO_FRAC_BITS_DEF = 14;

    // Hue geometry in whole degrees
    localparam int HUE_MOD    = 360;
    localparam int SECTOR_DEG = 120;

    // Q1.8 unity for saturation and intensity
    localparam int UNIT_Q8 = 256;

    // Register reset values
    localparam logic [7:0] RED_GAIN_RST = 8'd150;
    localparam logic [7:0] GB_GAIN_RST  = 8'd255;

    // Configuration register indexes
    localparam logic CFG_RED_GAIN = 1'b0;
    localparam logic CFG_GB_GAIN  = 1'b1;

    // Angle conversion, Q4.28 radians per degree
    localparam longint unsigned DEG_TO_RAD_Q28 = 64'd4685083;
    localparam int ANGLE_FRAC = 28;
    localparam int COS_TERMS  = 10;

    // Leading channel of a 120-degree hue sector
    typedef enum logic [1:0] {
        SECT_RED   = 2'd0,
        SECT_GREEN = 2'd1,
        SECT_BLUE  = 2'd2
    } t_sector;

endpackage

/* hdl/hsi_to_rgb_converter_core.sv */
// Top level: pipelined HSI to RGB pixel converter with gain registers.
//
// Converts one HSI pixel per clock to red, green and blue bytes. A request is
// taken whenever i_start is high (o_busy is always low) and its result shows
// on o_red/o_green/o_blue with o_valid, for one cycle, after the last stage; the
// receiver cannot stall, so the pipe never holds. The five stages are: hue
// reduction and sector split, lookup in a 120-entry constant table of
// cos(d)/cos(60-d) built at elaboration, the saturation products, the
// gain*intensity*factor product per channel, and the divide by three with
// saturation. Write the gains through i_cfg_* only while no request is in
// flight.
module hsi_to_rgb_converter_core
    import hsirgb_pkg::*;
#(
    parameter int RATIO_FRAC_BITS = RATIO_FRAC_BITS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    output logic       o_busy,
    input  logic [8:0] i_hue_degrees,
    input  logic [8:0] i_saturation,
    input  logic [8:0] i_intensity,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output logic       o_valid,
    output logic [7:0] o_red,
    output logic [7:0] o_green,
    output logic [7:0] o_blue
);

    // Ratio width (about -1..2), factor width, product width
    localparam int RW = RATIO_FRAC_BITS + 3;
    localparam int TW = RATIO_FRAC_BITS + 11;
    localparam int PW = 17 + TW - 1;
    localparam int NSTG = 5;

    localparam logic signed [RW-1:0] ONE  = RW'(longint'(1) <<< RATIO_FRAC_BITS);
    localparam logic signed [TW-1:0] BASE =
        TW'(longint'(UNIT_Q8) <<< RATIO_FRAC_BITS);

    // Floor divide by three of an 11-bit value, saturated to a byte
    function automatic logic [7:0] div3_sat(input logic [10:0] q);
        logic [20:0] prod;
        logic [9:0]  quo;
        prod = 21'(q) * 21'd683;
        quo  = prod[20:11];
        return (quo > 10'd255) ? 8'd255 : quo[7:0];
    endfunction

    // Gain registers
    logic [7:0] r_red_gain;
    logic [7:0] r_gb_gain;

    // Valid chain
    logic [NSTG-1:0] r_vld;
    logic            w_accept;

    // Stage 1
    logic [8:0] w_hue;
    t_sector    n_sector1;
    logic [8:0] n_d_wide;
    t_sector    r_sector1;
    logic [6:0] r_d;
    logic [8:0] r_s1;
    logic [8:0] r_i1;

    // Stage 2
    logic signed [RW-1:0] w_ratio_tab [SECTOR_DEG];
    logic signed [RW-1:0] r_ratio;
    t_sector              r_sector2;
    logic [8:0]           r_s2;
    logic [8:0]           r_i2;

    // Stage 3
    logic signed [RW-1:0] w_one_m_r;
    logic signed [TW-1:0] w_sr;
    logic signed [TW-1:0] w_sn;
    logic [8:0]           w_sinv;
    logic signed [TW-1:0] r_t_lead;
    logic signed [TW-1:0] r_t_next;
    logic signed [TW-1:0] r_t_last;
    logic [16:0]          r_gi_red;
    logic [16:0]          r_gi_gb;
    t_sector              r_sector3;

    // Stage 4
    logic signed [TW-1:0] w_tr;
    logic signed [TW-1:0] w_tg;
    logic signed [TW-1:0] w_tb;
    logic [TW-2:0]        w_ur;
    logic [TW-2:0]        w_ug;
    logic [TW-2:0]        w_ub;
    logic [PW-1:0]        r_p_red;
    logic [PW-1:0]        r_p_green;
    logic [PW-1:0]        r_p_blue;

    // Never hold off a request
    assign o_busy   = 1'b0;
    assign w_accept = i_start && !o_busy;
    assign o_valid  = r_vld[NSTG-1];

    // Write gain registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_red_gain <= RED_GAIN_RST;
            r_gb_gain  <= GB_GAIN_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RED_GAIN: r_red_gain <= i_cfg_data;
                CFG_GB_GAIN:  r_gb_gain  <= i_cfg_data;
                default:      r_red_gain <= r_red_gain;
            endcase
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[NSTG-2:0], w_accept};
        end
    end

    // Reduce hue and split into sector and offset
    always_comb begin
        w_hue = (i_hue_degrees >= 9'(HUE_MOD)) ? (i_hue_degrees - 9'(HUE_MOD))
                                               : i_hue_degrees;
        priority if (w_hue < 9'(SECTOR_DEG)) begin
            n_sector1 = SECT_RED;
            n_d_wide  = w_hue;
        end else if (w_hue < 9'(2 * SECTOR_DEG)) begin
            n_sector1 = SECT_GREEN;
            n_d_wide  = w_hue - 9'(SECTOR_DEG);
        end else begin
            n_sector1 = SECT_BLUE;
            n_d_wide  = w_hue - 9'(2 * SECTOR_DEG);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sector1 <= n_sector1;
        r_d       <= n_d_wide[6:0];
        r_s1      <= (i_saturation > 9'(UNIT_Q8)) ? 9'(UNIT_Q8) : i_saturation;
        r_i1      <= (i_intensity > 9'(UNIT_Q8)) ? 9'(UNIT_Q8) : i_intensity;
    end

    // Build the sector ratio table: cos(d) and cos(|60 - d|) as eleven-term Taylor
    // sums in Q28, then their quotient scaled to the ratio format
    for (genvar g = 0; g < SECTOR_DEG; g++) begin : g_tab
        localparam int              DM = (g <= 60) ? (60 - g) : (g - 60);
        localparam longint unsigned T0 = 64'd1 << ANGLE_FRAC;
        // Terms of cos(d)
        localparam longint unsigned XN  = 64'(g) * DEG_TO_RAD_Q28;
        localparam longint unsigned SN  = (XN * XN) >> ANGLE_FRAC;
        localparam longint unsigned N1  = ((T0 * SN) >> ANGLE_FRAC) / 64'd2;
        localparam longint unsigned N2  = ((N1 * SN) >> ANGLE_FRAC) / 64'd12;
        localparam longint unsigned N3  = ((N2 * SN) >> ANGLE_FRAC) / 64'd30;
        localparam longint unsigned N4  = ((N3 * SN) >> ANGLE_FRAC) / 64'd56;
        localparam longint unsigned N5  = ((N4 * SN) >> ANGLE_FRAC) / 64'd90;
        localparam longint unsigned N6  = ((N5 * SN) >> ANGLE_FRAC) / 64'd132;
        localparam longint unsigned N7  = ((N6 * SN) >> ANGLE_FRAC) / 64'd182;
        localparam longint unsigned N8  = ((N7 * SN) >> ANGLE_FRAC) / 64'd240;
        localparam longint unsigned N9  = ((N8 * SN) >> ANGLE_FRAC) / 64'd306;
        localparam longint unsigned N10 = ((N9 * SN) >> ANGLE_FRAC) / 64'd380;
        localparam longint CN = longint'(T0) - longint'(N1) + longint'(N2)
                              - longint'(N3) + longint'(N4) - longint'(N5)
                              + longint'(N6) - longint'(N7) + longint'(N8)
                              - longint'(N9) + longint'(N10);
        // Terms of cos(|60 - d|)
        localparam longint unsigned XD  = 64'(DM) * DEG_TO_RAD_Q28;
        localparam longint unsigned SD  = (XD * XD) >> ANGLE_FRAC;
        localparam longint unsigned D1  = ((T0 * SD) >> ANGLE_FRAC) / 64'd2;
        localparam longint unsigned D2  = ((D1 * SD) >> ANGLE_FRAC) / 64'd12;
        localparam longint unsigned D3  = ((D2 * SD) >> ANGLE_FRAC) / 64'd30;
        localparam longint unsigned D4  = ((D3 * SD) >> ANGLE_FRAC) / 64'd56;
        localparam longint unsigned D5  = ((D4 * SD) >> ANGLE_FRAC) / 64'd90;
        localparam longint unsigned D6  = ((D5 * SD) >> ANGLE_FRAC) / 64'd132;
        localparam longint unsigned D7  = ((D6 * SD) >> ANGLE_FRAC) / 64'd182;
        localparam longint unsigned D8  = ((D7 * SD) >> ANGLE_FRAC) / 64'd240;
        localparam longint unsigned D9  = ((D8 * SD) >> ANGLE_FRAC) / 64'd306;
        localparam longint unsigned D10 = ((D9 * SD) >> ANGLE_FRAC) / 64'd380;
        localparam longint CD = longint'(T0) - longint'(D1) + longint'(D2)
                              - longint'(D3) + longint'(D4) - longint'(D5)
                              + longint'(D6) - longint'(D7) + longint'(D8)
                              - longint'(D9) + longint'(D10);
        // Quotient truncated toward zero, denominator kept positive
        localparam longint DEN = (CD <= 0) ? longint'(1) : CD;
        localparam longint RV  = (CN * (longint'(1) <<< RATIO_FRAC_BITS)) / DEN;
        assign w_ratio_tab[g] = RV[RW-1:0];
    end

    // Look up the ratio
    always_ff @(posedge i_clk) begin
        r_ratio   <= w_ratio_tab[r_d];
        r_sector2 <= r_sector1;
        r_s2      <= r_s1;
        r_i2      <= r_i1;
    end

    // Form the three factors and the gain*intensity products
    always_comb begin
        w_one_m_r = ONE - r_ratio;
        w_sr      = TW'($signed({1'b0, r_s2})) * TW'(r_ratio);
        w_sn      = TW'($signed({1'b0, r_s2})) * TW'(w_one_m_r);
        w_sinv    = 9'(UNIT_Q8) - r_s2;
    end

    always_ff @(posedge i_clk) begin
        r_t_lead  <= BASE + w_sr;
        r_t_next  <= BASE + w_sn;
        r_t_last  <= TW'({w_sinv, {RATIO_FRAC_BITS{1'b0}}});
        r_gi_red  <= 17'(r_red_gain) * 17'(r_i2);
        r_gi_gb   <= 17'(r_gb_gain) * 17'(r_i2);
        r_sector3 <= r_sector2;
    end

    // Route factors to channels and drop negatives
    always_comb begin
        unique case (r_sector3)
            SECT_RED: begin
                w_tr = r_t_lead;
                w_tg = r_t_next;
                w_tb = r_t_last;
            end
            SECT_GREEN: begin
                w_tr = r_t_last;
                w_tg = r_t_lead;
                w_tb = r_t_next;
            end
            SECT_BLUE: begin
                w_tr = r_t_next;
                w_tg = r_t_last;
                w_tb = r_t_lead;
            end
            default: begin
                w_tr = '0;
                w_tg = '0;
                w_tb = '0;
            end
        endcase
        w_ur = w_tr[TW-1] ? '0 : w_tr[TW-2:0];
        w_ug = w_tg[TW-1] ? '0 : w_tg[TW-2:0];
        w_ub = w_tb[TW-1] ? '0 : w_tb[TW-2:0];
    end

    always_ff @(posedge i_clk) begin
        r_p_red   <= PW'(r_gi_red) * PW'(w_ur);
        r_p_green <= PW'(r_gi_gb) * PW'(w_ug);
        r_p_blue  <= PW'(r_gi_gb) * PW'(w_ub);
    end

    // Scale down, divide by three, saturate
    always_ff @(posedge i_clk) begin
        o_red   <= div3_sat(r_p_red[PW-1 -: 11]);
        o_green <= div3_sat(r_p_green[PW-1 -: 11]);
        o_blue  <= div3_sat(r_p_blue[PW-1 -: 11]);
    end

`ifndef SYNTHESIS
    // A request leaves the pipe as a valid result
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> ##5 o_valid)
        else $error("request lost in pipe");

    // A result always comes from a request
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(w_accept, 5))
        else $error("result without request");

    // Sector offset stays inside one sector
    a_offset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[0] |-> (r_d < 7'(SECTOR_DEG)))
        else $error("sector offset out of range");

    // Trailing factor is never negative
    a_last_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[2] |-> !r_t_last[TW-1])
        else $error("trailing factor negative");
`endif

endmodule

/* dv/hsi_to_rgb_converter_core_tb.sv */
// Self-checking testbench for the HSI to RGB pixel converter core.
module hsi_to_rgb_converter_core_tb
    import hsirgb_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF       = 10;
    localparam int RESET_CYCLES   = 10;
    localparam int FRAC           = RATIO_FRAC_BITS_DEF;
    localparam int PIPE_DEPTH     = 5;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam int NUM_DIRECTED   = 24;
    localparam int NUM_PHASES     = 7;
    localparam int PHASE_PIXELS   = 150;

    typedef longint unsigned t_u64;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // One directed request; known marks rows whose colors are typed in
    typedef struct packed {
        logic [8:0] hue;
        logic [8:0] sat;
        logic [8:0] inten;
        logic       known;
        t_rgb       color;
    } t_pixel_row;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_start = 1'b0;
    logic [8:0] i_hue_degrees = '0;
    logic [8:0] i_saturation = '0;
    logic [8:0] i_intensity = '0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_idx = CFG_RED_GAIN;
    logic [7:0] i_cfg_data = '0;
    logic       o_busy;
    logic       o_valid;
    logic [7:0] o_red;
    logic [7:0] o_green;
    logic [7:0] o_blue;

    // Gains as the converter holds them, mirrored for the color predictor
    logic [7:0] red_gain = RED_GAIN_RST;
    logic [7:0] gb_gain  = GB_GAIN_RST;

    t_rgb expected_rgb[$];
    int   mismatches = 0;
    int   pixels_sent = 0;
    int   pixels_checked = 0;
    int   idle_cycles = 0;
    int   idle_pct = 31;

    // Directed pixels at reset gains: clamps, sector edges, hue wrap, zero factors
    t_pixel_row directed_rows [NUM_DIRECTED] = '{
        '{9'd0,   9'd0,   9'd0,   1'b1, '{8'd0,  8'd0,  8'd0}},
        '{9'd511, 9'd511, 9'd0,   1'b1, '{8'd0,  8'd0,  8'd0}},
        '{9'd0,   9'd0,   9'd256, 1'b1, '{8'd50, 8'd85, 8'd85}},
        '{9'd359, 9'd0,   9'd511, 1'b1, '{8'd50, 8'd85, 8'd85}},
        '{9'd255, 9'd0,   9'd257, 1'b1, '{8'd50, 8'd85, 8'd85}},
        '{9'd0,   9'd256, 9'd256, 1'b0, '0},
        '{9'd60,  9'd256, 9'd256, 1'b0, '0},
        '{9'd119, 9'd256, 9'd256, 1'b0, '0},
        '{9'd120, 9'd256, 9'd256, 1'b0, '0},
        '{9'd180, 9'd256, 9'd256, 1'b0, '0},
        '{9'd239, 9'd256, 9'd256, 1'b0, '0},
        '{9'd240, 9'd256, 9'd256, 1'b0, '0},
        '{9'd300, 9'd256, 9'd256, 1'b0, '0},
        '{9'd359, 9'd256, 9'd256, 1'b0, '0},
        '{9'd360, 9'd256, 9'd256, 1'b0, '0},
        '{9'd480, 9'd256, 9'd256, 1'b0, '0},
        '{9'd511, 9'd511, 9'd511, 1'b0, '0},
        '{9'd1,   9'd256, 9'd256, 1'b0, '0},
        '{9'd121, 9'd257, 9'd300, 1'b0, '0},
        '{9'd241, 9'd128, 9'd200, 1'b0, '0},
        '{9'd90,  9'd1,   9'd1,   1'b0, '0},
        '{9'd30,  9'd255, 9'd255, 1'b0, '0},
        '{9'd300, 9'd511, 9'd128, 1'b0, '0},
        '{9'd170, 9'd170, 9'd85,  1'b0, '0}
    };

    // Gains per phase, red first; first is reset value; random gains in last phase
    logic [7:0] phase_gains [NUM_PHASES][2] = '{
        '{8'd150, 8'd255}, '{8'd0, 8'd0}, '{8'd255, 8'd255}, '{8'd255, 8'd0},
        '{8'd0, 8'd255}, '{8'd1, 8'd128}, '{8'd170, 8'd85}
    };

    wire req_taken = i_start && !o_busy;

    hsi_to_rgb_converter_core #(
        .RATIO_FRAC_BITS(FRAC)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_start),
        .o_busy       (o_busy),
        .i_hue_degrees(i_hue_degrees),
        .i_saturation (i_saturation),
        .i_intensity  (i_intensity),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .o_red        (o_red),
        .o_green      (o_green),
        .o_blue       (o_blue)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Cosine of whole degrees in Q28 by a truncated Taylor series
    function automatic longint taylor_cos(input int deg);
        longint unsigned angle;
        longint unsigned angle_sq;
        longint unsigned term;
        longint          acc;
        angle    = longint'(deg) * DEG_TO_RAD_Q28;
        angle_sq = (angle * angle) >> ANGLE_FRAC;
        term     = 64'd1 << ANGLE_FRAC;
        acc      = longint'(term);
        for (int n = 1; n <= COS_TERMS; n++) begin
            term = ((term * angle_sq) >> ANGLE_FRAC) / t_u64'((2 * n - 1) * (2 * n));
            if (n % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        return acc;
    endfunction

    // cos(d) / cos(|60 - d|) in Q.FRAC, truncated toward zero
    function automatic longint cos_ratio(input int d);
        int     mirror;
        longint den;
        mirror = (d <= 60) ? (60 - d) : (d - 60);
        den    = taylor_cos(mirror);
        if (den <= 0) begin
            den = 1;
        end
        return (taylor_cos(d) * (longint'(1) <<< FRAC)) / den;
    endfunction

    // gain * intensity * factor / (3 * 65536 * one), floored at zero, capped at 255
    function automatic logic [7:0] scale_channel(input logic [7:0] gain, input longint inten,
                                                 input longint factor);
        longint unsigned den;
        longint unsigned level;
        den = 64'd3 * 64'd65536 * (64'd1 << FRAC);
        if (factor <= 0) begin
            return 8'd0;
        end
        level = t_u64'(gain) * t_u64'(inten) * t_u64'(factor);
        level = level / den;
        return (level > 64'd255) ? 8'd255 : level[7:0];
    endfunction

    function automatic t_rgb predict_rgb(input logic [8:0] hue, input logic [8:0] sat,
                                         input logic [8:0] inten);
        int      wrapped;
        int      offset;
        t_sector sector;
        longint  one;
        longint  ratio;
        longint  s;
        longint  i;
        longint  f_lead;
        longint  f_next;
        longint  f_last;
        t_rgb    px;
        wrapped = int'(hue) % HUE_MOD;
        sector  = t_sector'(wrapped / SECTOR_DEG);
        offset  = wrapped % SECTOR_DEG;
        s       = (sat > UNIT_Q8) ? UNIT_Q8 : longint'(sat);
        i       = (inten > UNIT_Q8) ? UNIT_Q8 : longint'(inten);
        one     = longint'(1) <<< FRAC;
        ratio   = cos_ratio(offset);
        f_lead  = UNIT_Q8 * one + s * ratio;
        f_next  = UNIT_Q8 * one + s * (one - ratio);
        f_last  = UNIT_Q8 * one - s * one;
        // Rotate lead, next and last channels by sector
        case (sector)
            SECT_RED: begin
                px.red   = scale_channel(red_gain, i, f_lead);
                px.green = scale_channel(gb_gain, i, f_next);
                px.blue  = scale_channel(gb_gain, i, f_last);
            end
            SECT_GREEN: begin
                px.green = scale_channel(gb_gain, i, f_lead);
                px.blue  = scale_channel(gb_gain, i, f_next);
                px.red   = scale_channel(red_gain, i, f_last);
            end
            default: begin
                px.blue  = scale_channel(gb_gain, i, f_lead);
                px.red   = scale_channel(red_gain, i, f_next);
                px.green = scale_channel(gb_gain, i, f_last);
            end
        endcase
        return px;
    endfunction

    // Issue one request after a random gap; queue its colors once taken
    task automatic send_pixel(input logic [8:0] hue, input logic [8:0] sat,
                              input logic [8:0] inten, input logic known, input t_rgb color);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start       <= 1'b1;
        i_hue_degrees <= hue;
        i_saturation  <= sat;
        i_intensity   <= inten;
        do @(posedge i_clk); while (o_busy);
        expected_rgb.push_back(known ? color : predict_rgb(hue, sat, inten));
        pixels_sent++;
    endtask

    // Hold requests off until every pending color is back and the pipe is empty
    task automatic drain_pipe();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (expected_rgb.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic program_gains(input logic [7:0] red_val, input logic [7:0] gb_val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= CFG_RED_GAIN;
        i_cfg_data <= red_val;
        @(posedge i_clk);
        i_cfg_idx  <= CFG_GB_GAIN;
        i_cfg_data <= gb_val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        red_gain = red_val;
        gb_gain  = gb_val;
    endtask

    function automatic logic [8:0] pick_level();
        case ($urandom_range(0, 9))
            0:       return 9'($urandom_range(257, 511));
            1:       return ($urandom_range(0, 1) == 1) ? 9'd256 : 9'd0;
            default: return 9'($urandom_range(0, 256));
        endcase
    endfunction

    // Compare each returned pixel with the oldest pending one
    always @(posedge i_clk) begin
        t_rgb want;
        if (i_rst_n && o_valid) begin
            if (expected_rgb.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("[%0t] unexpected pixel r=%0d g=%0d b=%0d",
                             $realtime, o_red, o_green, o_blue);
                end
            end else begin
                want = expected_rgb.pop_front();
                pixels_checked++;
                if (o_red !== want.red || o_green !== want.green || o_blue !== want.blue) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("[%0t] pixel %0d: want r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                                 $realtime, pixels_checked - 1, want.red, want.green,
                                 want.blue, o_red, o_green, o_blue);
                    end
                end
            end
        end
    end

    // Abort when neither a request nor a pixel moves for too long
    always @(posedge i_clk) begin
        if (req_taken || o_valid) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout after %0d quiet cycles", idle_cycles);
            $display("FAIL hsi_to_rgb_converter_core");
            $finish;
        end
    end

    initial begin
        int random_sent;
        random_sent = 0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed rows at reset gains
        foreach (directed_rows[k]) begin
            send_pixel(directed_rows[k].hue, directed_rows[k].sat, directed_rows[k].inten,
                       directed_rows[k].known, directed_rows[k].color);
        end

        // Random pixels per gain setting; sender idle share goes 31, 62, then 0 pct
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_pipe();
            if (p == NUM_PHASES - 1) begin
                program_gains(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
            end else begin
                program_gains(phase_gains[p][0], phase_gains[p][1]);
            end
            for (int n = 0; n < PHASE_PIXELS; n++) begin
                idle_pct = (random_sent < 350) ? 31 : (random_sent < 700) ? 62 : 0;
                send_pixel(9'($urandom_range(0, 511)), pick_level(), pick_level(), 1'b0, '0);
                random_sent++;
            end
        end

        drain_pipe();
        if (expected_rgb.size() != 0) begin
            mismatches += expected_rgb.size();
        end
        $display("Sent %0d pixels over %0d gain settings, checked %0d, mismatches %0d",
                 pixels_sent, NUM_PHASES, pixels_checked, mismatches);
        $display("Covered hue wrap, sector edges, level clamps and idle gaps of 31/62/0 pct");
        if (mismatches == 0) begin
            $display("PASS hsi_to_rgb_converter_core");
        end else begin
            $display("FAIL hsi_to_rgb_converter_core");
        end
        $finish;
    end

endmodule
